/* rtl/tmpa_pkg.sv */
// ----------------------------------------------------------------------------
// tmpa_pkg: shared types and constants of the token mutex priority arbiter
// Sizes, opcode and result codes, the microcode word format and the
// read-only control program run by the sequencer.
// ----------------------------------------------------------------------------
package tmpa_pkg;

   // sizes
   localparam int NODES    = 8;
   localparam int SEQ_BITS = 16;
   localparam int IDX_W    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int UPC_W    = 4;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NODES - 1);
   localparam logic [2:0]       PRIO_NONE = 3'd5;

   // configuration register index (byte address bit 2)
   localparam logic CSR_SELF_NODE = 1'b0;

   typedef enum logic [2:0] {
      OP_REMOTE = 3'd0,
      OP_MERGE  = 3'd1,
      OP_LREQ   = 3'd2,
      OP_LDONE  = 3'd3,
      OP_IDLE   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_STALE = 2'd1,
      KIND_TOKEN = 2'd2
   } kind_type;

   // sequencer state
   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // microcode fields
   typedef enum logic [1:0] {
      ASEL_NODE,
      ASEL_SELF,
      ASEL_IDX
   } asel_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_REMOTE,
      ACT_MERGE,
      ACT_LREQ,
      ACT_DONE,
      ACT_BEST_INIT,
      ACT_SCAN,
      ACT_IDX_CLR,
      ACT_SEND
   } act_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_ACK,
      EMIT_STALE,
      EMIT_TOKEN
   } emit_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_STALE,
      COND_PASS,
      COND_NO_TOKEN,
      COND_MORE,
      COND_BEST_SELF
   } cond_type;

   typedef struct packed {
      asel_type         asel;
      act_type          act;
      emit_type         emit;
      cond_type         cond;
      logic [UPC_W-1:0] target;
      logic             fin;
   } ucode_type;

   // datapath flags tested by the sequencer
   typedef struct packed {
      logic stale;
      logic pass;
      logic token;
      logic more;
      logic best_self;
   } ucond_type;

   // program addresses
   localparam logic [UPC_W-1:0] UPC_R_CHK  = 4'd0;
   localparam logic [UPC_W-1:0] UPC_R_UPD  = 4'd1;
   localparam logic [UPC_W-1:0] UPC_ACK    = 4'd2;
   localparam logic [UPC_W-1:0] UPC_STALE  = 4'd3;
   localparam logic [UPC_W-1:0] UPC_MERGE  = 4'd4;
   localparam logic [UPC_W-1:0] UPC_LREQ   = 4'd5;
   localparam logic [UPC_W-1:0] UPC_DONE   = 4'd6;
   localparam logic [UPC_W-1:0] UPC_P_INIT = 4'd7;
   localparam logic [UPC_W-1:0] UPC_P_SCAN = 4'd8;
   localparam logic [UPC_W-1:0] UPC_P_CHK  = 4'd9;
   localparam logic [UPC_W-1:0] UPC_P_SEND = 4'd10;

   function automatic ucode_type uword(asel_type a, act_type c, emit_type e,
                                       cond_type j, logic [UPC_W-1:0] t,
                                       logic f);
      ucode_type w;
      w.asel   = a;
      w.act    = c;
      w.emit   = e;
      w.cond   = j;
      w.target = t;
      w.fin    = f;
      return w;
   endfunction

   // control program: jump if cond, else finish if fin, else step on
   function automatic ucode_type ucode_rom(logic [UPC_W-1:0] pc);
      ucode_type w;
      case (pc)
         UPC_R_CHK:  w = uword(ASEL_NODE, ACT_NONE, EMIT_NONE, COND_STALE,
                               UPC_STALE, 1'b0);
         UPC_R_UPD:  w = uword(ASEL_NODE, ACT_REMOTE, EMIT_NONE, COND_PASS,
                               UPC_P_INIT, 1'b0);
         UPC_ACK:    w = uword(ASEL_SELF, ACT_NONE, EMIT_ACK, COND_NEVER,
                               UPC_ACK, 1'b1);
         UPC_STALE:  w = uword(ASEL_SELF, ACT_NONE, EMIT_STALE, COND_NEVER,
                               UPC_ACK, 1'b1);
         UPC_MERGE:  w = uword(ASEL_NODE, ACT_MERGE, EMIT_NONE, COND_ALWAYS,
                               UPC_ACK, 1'b0);
         UPC_LREQ:   w = uword(ASEL_SELF, ACT_LREQ, EMIT_NONE, COND_ALWAYS,
                               UPC_ACK, 1'b0);
         UPC_DONE:   w = uword(ASEL_SELF, ACT_DONE, EMIT_NONE, COND_NO_TOKEN,
                               UPC_ACK, 1'b0);
         UPC_P_INIT: w = uword(ASEL_SELF, ACT_BEST_INIT, EMIT_NONE, COND_NEVER,
                               UPC_ACK, 1'b0);
         UPC_P_SCAN: w = uword(ASEL_IDX, ACT_SCAN, EMIT_NONE, COND_MORE,
                               UPC_P_SCAN, 1'b0);
         UPC_P_CHK:  w = uword(ASEL_SELF, ACT_IDX_CLR, EMIT_NONE, COND_BEST_SELF,
                               UPC_ACK, 1'b0);
         UPC_P_SEND: w = uword(ASEL_IDX, ACT_SEND, EMIT_TOKEN, COND_MORE,
                               UPC_P_SEND, 1'b1);
         default:    w = uword(ASEL_SELF, ACT_NONE, EMIT_ACK, COND_NEVER,
                               UPC_ACK, 1'b1);
      endcase
      return w;
   endfunction

   // own index, saturated into the table
   function automatic logic [IDX_W-1:0] self_sat(logic [2:0] s);
      logic [IDX_W-1:0] r;
      if (int'(s) >= NODES) r = LAST_IDX;
      else                  r = IDX_W'(s);
      return r;
   endfunction

endpackage

/* rtl/tmpa_if.sv */
// ----------------------------------------------------------------------------
// tmpa_if: item channels of the token mutex priority arbiter
// Valid/ready channels for incoming operations and outgoing results.
// ----------------------------------------------------------------------------
interface tmpa_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [2:0]  node;
   logic [15:0] request_number;
   logic [2:0]  priority_req;
   logic        local_busy;
   logic        last_word;

   modport source (output valid, opcode, node, request_number, priority_req,
                   local_busy, last_word, input ready);
   modport sink   (input valid, opcode, node, request_number, priority_req,
                   local_busy, last_word, output ready);
endinterface

interface tmpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [2:0]  dest_node;
   logic [2:0]  entry_index;
   logic [15:0] served_value;
   logic        token_here;
   logic        last;

   modport source (output valid, result_kind, dest_node, entry_index,
                   served_value, token_here, last, input ready);
   modport sink   (input valid, result_kind, dest_node, entry_index,
                   served_value, token_here, last, output ready);
endinterface

/* rtl/token_mutex_priority_arbiter_core.sv */
// ----------------------------------------------------------------------------
// token_mutex_priority_arbiter_core: token mutual exclusion node
// Per-node request, priority and served tables with a microcoded datapath.
// ----------------------------------------------------------------------------
// Results: one ack or stale word per item, also when a priority scan finds
//   nobody else pending; else token words follow the scan, one per table entry,
//   the last one flagged by last.
// Throughput: one item at a time; the next is taken the cycle after the last
//   result is registered.
// Reset: synchronous; a self_node write also re-initialises all tables.
module token_mutex_priority_arbiter_core (
   input  logic        clock,
   input  logic        reset,
   tmpa_req_if.sink    req_chan,
   tmpa_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tmpa_pkg::*;

   // tables and scalar state
   logic [SEQ_BITS-1:0] req_tab_ff  [NODES];
   logic [SEQ_BITS-1:0] req_tab_in  [NODES];
   logic [2:0]          prio_tab_ff [NODES];
   logic [2:0]          prio_tab_in [NODES];
   logic [SEQ_BITS-1:0] srv_tab_ff  [NODES];
   logic [SEQ_BITS-1:0] srv_tab_in  [NODES];
   logic [SEQ_BITS-1:0] own_ff, own_in;
   logic [SEQ_BITS-1:0] high_ff, high_in;
   logic                tok_ff, tok_in;
   logic [2:0]          self_ff, self_in;

   // scan registers
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [SEQ_BITS-1:0] best_req_ff, best_req_in;
   logic [2:0]          best_prio_ff, best_prio_in;

   // captured item
   logic [2:0]          in_node_ff;
   logic [SEQ_BITS-1:0] in_num_ff;
   logic [2:0]          in_prio_ff;
   logic                in_busy_ff;
   logic                in_lastw_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [2:0]          dest_ff, dest_in;
   logic [2:0]          entry_ff, entry_in;
   logic [15:0]         val_ff, val_in;
   logic                here_ff, here_in;
   logic                last_ff, last_in;

   logic                req_acc;
   logic                cfg_wr;
   logic                init;
   logic [2:0]          init_self;
   logic [IDX_W-1:0]    init_me;
   logic [IDX_W-1:0]    me;
   logic [IDX_W-1:0]    addr;
   logic [SEQ_BITS-1:0] rd_req;
   logic [2:0]          rd_prio;
   logic [SEQ_BITS-1:0] rd_srv;
   logic                better;
   logic                emit;
   logic                stall;
   logic                seq_busy;
   logic                step_en;
   ucode_type           uc;
   ucond_type           cond;

   // configuration port
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_SELF_NODE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_SELF_NODE) ? 32'(self_ff) : '0;

   assign init      = reset || cfg_wr;
   assign init_self = reset ? 3'd0 : csr_pwdata[2:0];
   assign init_me   = self_sat(init_self);
   assign me        = self_sat(self_ff);

   // handshake
   assign req_chan.ready = !seq_busy;
   assign req_acc        = req_chan.valid && !seq_busy;
   assign stall          = rsp_valid_ff && !rsp_chan.ready;

   tmpa_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (req_acc),
      .start_op      (req_chan.opcode),
      .start_node_ok (int'(req_chan.node) < NODES),
      .cond          (cond),
      .stall         (stall),
      .busy          (seq_busy),
      .step_en       (step_en),
      .uc            (uc)
   );

   // table read port
   always_comb begin
      case (uc.asel)
         ASEL_NODE: addr = IDX_W'(in_node_ff);
         ASEL_IDX:  addr = idx_ff;
         default:   addr = me;
      endcase
   end
   assign rd_req  = req_tab_ff[addr];
   assign rd_prio = prio_tab_ff[addr];
   assign rd_srv  = srv_tab_ff[addr];

   // candidate beats current best: class, then number, then index
   always_comb begin
      if (rd_prio == best_prio_ff)
         better = (rd_req < best_req_ff) ||
                  ((rd_req == best_req_ff) && (idx_ff <= best_idx_ff));
      else
         better = (rd_prio < best_prio_ff);
      better = better && (rd_req > rd_srv);
   end

   // flags for jumps
   always_comb begin
      cond.stale     = (in_num_ff <= rd_srv);
      cond.pass      = tok_ff && !in_busy_ff;
      cond.token     = tok_ff;
      cond.more      = (idx_ff != LAST_IDX);
      cond.best_self = (best_idx_ff == me);
   end

   // datapath next values
   always_comb begin
      req_tab_in   = req_tab_ff;
      prio_tab_in  = prio_tab_ff;
      srv_tab_in   = srv_tab_ff;
      own_in       = own_ff;
      high_in      = high_ff;
      tok_in       = tok_ff;
      self_in      = self_ff;
      idx_in       = idx_ff;
      best_idx_in  = best_idx_ff;
      best_req_in  = best_req_ff;
      best_prio_in = best_prio_ff;
      if (init) begin
         self_in = init_self;
         for (int i = 0; i < NODES; i++) begin
            req_tab_in[i]  = (IDX_W'(i) == init_me) ? SEQ_BITS'(1) : '0;
            prio_tab_in[i] = (IDX_W'(i) == init_me) ? PRIO_NONE : 3'd0;
            srv_tab_in[i]  = '0;
         end
         own_in  = SEQ_BITS'(1);
         high_in = '0;
         tok_in  = (init_self == 3'd0);
      end else if (step_en) begin
         case (uc.act)
            ACT_REMOTE: begin
               if ((in_prio_ff < rd_prio) || (rd_req <= rd_srv)) begin
                  req_tab_in[addr]  = in_num_ff;
                  prio_tab_in[addr] = in_prio_ff;
               end
               if (own_ff < in_num_ff) high_in = in_num_ff;
            end
            ACT_MERGE: begin
               if (in_num_ff > rd_srv) srv_tab_in[addr] = in_num_ff;
               if (in_lastw_ff) tok_in = 1'b1;
            end
            ACT_LREQ: begin
               high_in           = high_ff + 1'b1;
               own_in            = high_ff + 1'b1;
               req_tab_in[addr]  = high_ff + 1'b1;
               prio_tab_in[addr] = in_prio_ff;
            end
            ACT_DONE: begin
               srv_tab_in[addr]  = own_ff;
               own_in            = own_ff + 1'b1;
               req_tab_in[addr]  = own_ff + 1'b1;
               prio_tab_in[addr] = in_prio_ff;
            end
            ACT_BEST_INIT: begin
               best_idx_in  = me;
               best_req_in  = rd_req;
               best_prio_in = rd_prio;
               idx_in       = '0;
            end
            ACT_SCAN: begin
               if (better) begin
                  best_idx_in  = idx_ff;
                  best_req_in  = rd_req;
                  best_prio_in = rd_prio;
               end
               idx_in = idx_ff + 1'b1;
            end
            ACT_IDX_CLR: idx_in = '0;
            ACT_SEND: begin
               tok_in = 1'b0;
               idx_in = idx_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // result register
   assign emit = step_en && (uc.emit != EMIT_NONE);
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      kind_in      = kind_ff;
      dest_in      = dest_ff;
      entry_in     = entry_ff;
      val_in       = val_ff;
      here_in      = here_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         case (uc.emit)
            EMIT_TOKEN: begin
               kind_in  = KIND_TOKEN;
               dest_in  = 3'(best_idx_ff);
               entry_in = 3'(idx_ff);
               val_in   = 16'(rd_srv);
               here_in  = 1'b0;
               last_in  = !cond.more;
            end
            EMIT_STALE: begin
               kind_in  = KIND_STALE;
               dest_in  = '0;
               entry_in = '0;
               val_in   = '0;
               here_in  = tok_ff;
               last_in  = 1'b1;
            end
            default: begin
               kind_in  = KIND_ACK;
               dest_in  = '0;
               entry_in = '0;
               val_in   = '0;
               here_in  = tok_ff;
               last_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      req_tab_ff   <= req_tab_in;
      prio_tab_ff  <= prio_tab_in;
      srv_tab_ff   <= srv_tab_in;
      own_ff       <= own_in;
      high_ff      <= high_in;
      tok_ff       <= tok_in;
      self_ff      <= self_in;
      idx_ff       <= idx_in;
      best_idx_ff  <= best_idx_in;
      best_req_ff  <= best_req_in;
      best_prio_ff <= best_prio_in;
      kind_ff      <= kind_in;
      dest_ff      <= dest_in;
      entry_ff     <= entry_in;
      val_ff       <= val_in;
      here_ff      <= here_in;
      last_ff      <= last_in;
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // item capture
   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_node_ff  <= req_chan.node;
         in_num_ff   <= SEQ_BITS'(req_chan.request_number);
         in_prio_ff  <= req_chan.priority_req;
         in_busy_ff  <= req_chan.local_busy;
         in_lastw_ff <= req_chan.last_word;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = kind_ff;
   assign rsp_chan.dest_node    = dest_ff;
   assign rsp_chan.entry_index  = entry_ff;
   assign rsp_chan.served_value = val_ff;
   assign rsp_chan.token_here   = here_ff;
   assign rsp_chan.last         = last_ff;

   // checks
   a_send_drops_token: assert property (@(posedge clock) disable iff (reset)
      (step_en && (uc.emit == EMIT_TOKEN)) |=> !tok_ff)
      else $error("token still held after a token word went out");

   a_best_in_table: assert property (@(posedge clock) disable iff (reset)
      (seq_busy && (uc.act == ACT_SEND)) |-> (best_idx_ff <= LAST_IDX))
      else $error("handover destination outside the table");

   a_send_not_self: assert property (@(posedge clock) disable iff (reset)
      (step_en && (uc.emit == EMIT_TOKEN)) |-> (best_idx_ff != me))
      else $error("token handed to this node itself");

endmodule

/* rtl/tmpa_seq.sv */
// ----------------------------------------------------------------------------
// tmpa_seq: microcode sequencer
// Dispatches an accepted item to its routine, fetches one control word per
// step from the program table and resolves conditional jumps.
// ----------------------------------------------------------------------------
module tmpa_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2:0]          start_op,
   input  logic                start_node_ok,
   input  tmpa_pkg::ucond_type cond,
   input  logic                stall,
   output logic                busy,
   output logic                step_en,
   output tmpa_pkg::ucode_type uc
);
   import tmpa_pkg::*;

   seq_state_type    state_ff, state_in;
   logic [UPC_W-1:0] pc_ff, pc_in;
   logic [UPC_W-1:0] entry;
   logic             jump;

   // routine entry per opcode
   always_comb begin
      case (opcode_type'(start_op))
         OP_REMOTE: entry = start_node_ok ? UPC_R_CHK : UPC_ACK;
         OP_MERGE:  entry = start_node_ok ? UPC_MERGE : UPC_ACK;
         OP_LREQ:   entry = UPC_LREQ;
         OP_LDONE:  entry = UPC_DONE;
         default:   entry = UPC_ACK;
      endcase
   end

   // outputs: current control word, step enable
   always_comb begin
      uc      = ucode_rom(pc_ff);
      busy    = (state_ff == SEQ_RUN);
      step_en = busy && !((uc.emit != EMIT_NONE) && stall);
   end

   // jump condition
   always_comb begin
      case (uc.cond)
         COND_ALWAYS:    jump = 1'b1;
         COND_STALE:     jump = cond.stale;
         COND_PASS:      jump = cond.pass;
         COND_NO_TOKEN:  jump = !cond.token;
         COND_MORE:      jump = cond.more;
         COND_BEST_SELF: jump = cond.best_self;
         default:        jump = 1'b0;
      endcase
   end

   // next state and step counter
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               pc_in    = entry;
            end
         end
         SEQ_RUN: begin
            if (step_en) begin
               if (jump)        pc_in    = uc.target;
               else if (uc.fin) state_in = SEQ_IDLE;
               else             pc_in    = pc_ff + 1'b1;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= UPC_ACK;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   // checks
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start the program");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (pc_ff <= UPC_P_SEND))
      else $error("step counter outside the program");

endmodule
